// File: sv/frp_pkg.sv
// shared types and constants for the framed packet receiver
// no dependencies

package frp_pkg;

    // receiver phases, the first six follow the frame layout
    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_ADDR  = 3'd1,
        PH_FUNC  = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CSUM  = 3'd5,
        PH_DRAIN = 3'd6
    } t_phase;

    localparam logic [7:0] HEAD_RESET = 8'hAA;

endpackage

// File: sv/framed_packet_receiver_sum_checksum.sv
// framed packet receiver with 8-bit sum checksum, top level
// depends on frp_pkg and frp_ram

// usage
//   input channel: one received byte per beat on i_rx_byte, i_valid / o_stall
//   output channel: one payload byte per beat with frame address, function,
//     length, index, empty and last marks, o_valid / i_stall
//   config channel: i_cfg_valid / o_cfg_ready carry the head byte value,
//     ready is always high; write it only while the block is idle
// a frame is head, address, function, length, payload, checksum; the checksum
// is the wrapping sum of address, function, length and payload bytes
// the payload goes into a one-port-write, one-port-read buffer whose read
// data is registered; after a good checksum the input is stalled while the
// buffer drains: the phase register, the buffer read register and the output
// register lie between the checksum beat and the first result beat, then one
// beat per cycle follows while the receiver does not stall; the input is held
// until the last beat reaches the output register (an empty frame counts as
// one beat)
// a bad checksum or an oversized length gives no result, the block hunts again
// when the receiver stalls, the output register holds its beat and the drain
// pauses, with at most one read in flight
// reset (synchronous, active low) returns to hunting with head byte 0xAA;
// the buffer itself is not cleared, only entries of the current frame are read

module framed_packet_receiver_sum_checksum
    import frp_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // received bytes
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    // validated frame beats
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_frame_addr,
    output logic [7:0] o_frame_func,
    output logic [6:0] o_frame_len,
    output logic [7:0] o_payload_byte,
    output logic [5:0] o_payload_index,
    output logic       o_empty_frame,
    output logic       o_last,
    // head byte register
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    localparam int         AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [6:0] MAX7  = 7'(MAX_PAYLOAD);
    localparam logic [7:0] MAX8  = 8'(MAX_PAYLOAD);

    t_phase     r_phase, n_phase;
    logic [7:0] r_head;
    logic [7:0] r_addr;
    logic [7:0] r_func;
    logic [6:0] r_len;
    logic [6:0] r_cnt;
    logic [7:0] r_sum;

    // drain side
    logic [6:0] r_rd_cnt;
    logic       r_rd_vld;
    logic [5:0] r_rd_idx;
    logic       r_rd_last;
    logic       r_rd_empty;
    logic [7:0] ram_rdata;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_addr;
    logic [7:0] r_out_func;
    logic [6:0] r_out_len;
    logic [7:0] r_out_byte;
    logic [5:0] r_out_idx;
    logic       r_out_empty;
    logic       r_out_last;

    logic       in_acc;
    logic       in_open;
    logic [6:0] cnt_inc;
    logic [7:0] sum_add;
    logic       csum_ok;
    logic       ram_we;
    logic       out_free;
    logic       move;
    logic [6:0] target;
    logic       remaining;
    logic       issue;
    logic       drain_done;

    assign in_acc   = i_valid && !o_stall;
    assign cnt_inc  = r_cnt + 7'd1;
    assign sum_add  = r_sum + i_rx_byte;
    assign csum_ok  = in_acc && (r_phase == PH_CSUM) && (i_rx_byte == r_sum);
    // guard keeps writes inside the buffer even for odd lengths
    assign ram_we   = in_acc && (r_phase == PH_DATA) && (r_cnt < MAX7);

    // an empty frame drains as one beat with masked data
    assign out_free   = !r_out_valid || !i_stall;
    assign move       = r_rd_vld && out_free;
    assign target     = (r_len == 7'd0) ? 7'd1 : r_len;
    assign remaining  = (r_rd_cnt != target);
    assign issue      = (r_phase == PH_DRAIN) && remaining && (!r_rd_vld || out_free);
    assign drain_done = !remaining && (!r_rd_vld || out_free);

    // next state
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HUNT: begin
                if (in_acc && (i_rx_byte == r_head)) n_phase = PH_ADDR;
            end
            PH_ADDR: begin
                if (in_acc) n_phase = PH_FUNC;
            end
            PH_FUNC: begin
                if (in_acc) n_phase = PH_LEN;
            end
            PH_LEN: begin
                if (in_acc) begin
                    if (i_rx_byte > MAX8)        n_phase = PH_HUNT;
                    else if (i_rx_byte == 8'd0)  n_phase = PH_CSUM;
                    else                         n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (in_acc && (cnt_inc >= r_len)) n_phase = PH_CSUM;
            end
            PH_CSUM: begin
                if (in_acc) n_phase = csum_ok ? PH_DRAIN : PH_HUNT;
            end
            PH_DRAIN: begin
                if (drain_done) n_phase = PH_HUNT;
            end
            default: n_phase = PH_HUNT;
        endcase
    end

    // state outputs: the input waits while the buffer drains, which also
    // keeps buffer writes and reads of the same entry from overlapping
    always_comb begin
        in_open = 1'b1;
        unique case (r_phase)
            PH_DRAIN: in_open = 1'b0;
            default:  in_open = 1'b1;
        endcase
    end

    assign o_stall     = !in_open;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_head  <= HEAD_RESET;
        end else begin
            r_phase <= n_phase;
            if (i_cfg_valid && o_cfg_ready) begin
                r_head <= i_cfg_data;
            end
        end
    end

    // header capture, byte count and running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_func <= '0;
            r_len  <= '0;
            r_cnt  <= '0;
            r_sum  <= '0;
        end else if (in_acc) begin
            case (r_phase)
                PH_ADDR: begin
                    r_addr <= i_rx_byte;
                    r_sum  <= i_rx_byte;
                end
                PH_FUNC: begin
                    r_func <= i_rx_byte;
                    r_sum  <= sum_add;
                end
                PH_LEN: begin
                    r_cnt <= '0;
                    if (i_rx_byte <= MAX8) begin
                        r_len <= i_rx_byte[6:0];
                        r_sum <= sum_add;
                    end
                end
                PH_DATA: begin
                    r_sum <= sum_add;
                    r_cnt <= cnt_inc;
                end
                default: ;
            endcase
        end
    end

    frp_ram #(
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (issue),
        .i_raddr (r_rd_cnt[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // read sequencer, one read in flight at most
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_cnt <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (csum_ok) begin
                r_rd_cnt <= '0;
            end else if (issue) begin
                r_rd_cnt <= r_rd_cnt + 7'd1;
            end
            if (issue) begin
                r_rd_vld <= 1'b1;
            end else if (move) begin
                r_rd_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_idx   <= r_rd_cnt[5:0];
            r_rd_last  <= (r_rd_cnt + 7'd1 == target);
            r_rd_empty <= (r_len == 7'd0);
        end
    end

    // output register, holds while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_addr  <= r_addr;
            r_out_func  <= r_func;
            r_out_len   <= r_len;
            r_out_byte  <= r_rd_empty ? 8'd0 : ram_rdata;
            r_out_idx   <= r_rd_idx;
            r_out_empty <= r_rd_empty;
            r_out_last  <= r_rd_last;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_frame_addr    = r_out_addr;
    assign o_frame_func    = r_out_func;
    assign o_frame_len     = r_out_len;
    assign o_payload_byte  = r_out_byte;
    assign o_payload_index = r_out_idx;
    assign o_empty_frame   = r_out_empty;
    assign o_last          = r_out_last;

endmodule

// File: sv/frp_ram.sv
// payload buffer: one write port, one read port with registered read data
// no package dependencies

module frp_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/frp_check.sv
// port-level checks for the framed packet receiver, bound to the top level
// no package dependencies

module frp_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [6:0] o_frame_len,
    input logic [7:0] o_payload_byte,
    input logic [5:0] o_payload_index,
    input logic       o_empty_frame,
    input logic       o_last
);

    // a stalled beat stays
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output beat dropped under stall");

    // empty frame beat is a lone, zeroed, last beat
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_empty_frame |-> o_last && (o_payload_byte == 8'd0)
            && (o_payload_index == 6'd0) && (o_frame_len == 7'd0))
        else $error("malformed empty frame beat");

    // payload index stays within the frame
    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_empty_frame |-> (o_frame_len != 7'd0)
            && ({1'b0, o_payload_index} < o_frame_len))
        else $error("payload index out of frame");

    // last mark sits on the final index
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_empty_frame && o_last
            |-> ({1'b0, o_payload_index} + 7'd1 == o_frame_len))
        else $error("last mark on wrong index");

    // next beat after a delivered non-last beat continues the index
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last && o_valid
            ##1 o_valid |-> (o_payload_index == $past(o_payload_index) + 6'd1))
        else $error("payload index out of order");

endmodule

bind framed_packet_receiver_sum_checksum frp_check u_frp_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_frame_len     (o_frame_len),
    .o_payload_byte  (o_payload_byte),
    .o_payload_index (o_payload_index),
    .o_empty_frame   (o_empty_frame),
    .o_last          (o_last)
);
